### rtl/aio_pkg.sv
package aio_pkg;

  localparam int DATA_W = 64;
  localparam int FUNC_W = 5;
  localparam int COND_W = 3;

  typedef logic [DATA_W-1:0] data_t;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 5'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUB    = 5'd1;
  localparam logic [FUNC_W-1:0] FUNC_AND    = 5'd2;
  localparam logic [FUNC_W-1:0] FUNC_OR     = 5'd3;
  localparam logic [FUNC_W-1:0] FUNC_XOR    = 5'd4;
  localparam logic [FUNC_W-1:0] FUNC_SLL    = 5'd5;
  localparam logic [FUNC_W-1:0] FUNC_SRL    = 5'd6;
  localparam logic [FUNC_W-1:0] FUNC_SRA    = 5'd7;
  localparam logic [FUNC_W-1:0] FUNC_ZAP    = 5'd8;
  localparam logic [FUNC_W-1:0] FUNC_CMPEQ  = 5'd9;
  localparam logic [FUNC_W-1:0] FUNC_CMPLT  = 5'd10;
  localparam logic [FUNC_W-1:0] FUNC_CMPLE  = 5'd11;
  localparam logic [FUNC_W-1:0] FUNC_CMPULT = 5'd12;
  localparam logic [FUNC_W-1:0] FUNC_CMPULE = 5'd13;
  localparam logic [FUNC_W-1:0] FUNC_CMPBGE = 5'd14;
  localparam logic [FUNC_W-1:0] FUNC_CMOV   = 5'd15;
  localparam logic [FUNC_W-1:0] FUNC_INS    = 5'd16;
  localparam logic [FUNC_W-1:0] FUNC_EXT    = 5'd17;
  localparam logic [FUNC_W-1:0] FUNC_MSK    = 5'd18;

  // conditional move tests
  localparam logic [COND_W-1:0] COND_EQ  = 3'd0;
  localparam logic [COND_W-1:0] COND_NE  = 3'd1;
  localparam logic [COND_W-1:0] COND_LT  = 3'd2;
  localparam logic [COND_W-1:0] COND_GE  = 3'd3;
  localparam logic [COND_W-1:0] COND_LE  = 3'd4;
  localparam logic [COND_W-1:0] COND_GT  = 3'd5;
  localparam logic [COND_W-1:0] COND_LBS = 3'd6;
  localparam logic [COND_W-1:0] COND_LBC = 3'd7;

  // operand a scaling
  localparam logic [1:0] SCALE_X4 = 2'd1;
  localparam logic [1:0] SCALE_X8 = 2'd2;

  // byte field widths
  localparam logic [1:0] BW_BYTE = 2'd0;
  localparam logic [1:0] BW_WORD = 2'd1;
  localparam logic [1:0] BW_LONG = 2'd2;

endpackage

### rtl/aio_if.sv
interface aio_in_if import aio_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic              invert_b;
  logic [1:0]        scale;
  logic              longword;
  logic [1:0]        byte_width;
  logic              high_part;
  logic [COND_W-1:0] cond;
  data_t             operand_a;
  data_t             operand_b;
  data_t             old_dest;

  modport source (
    output valid, func, invert_b, scale, longword, byte_width, high_part, cond,
           operand_a, operand_b, old_dest,
    input  ready
  );
  modport sink (
    input  valid, func, invert_b, scale, longword, byte_width, high_part, cond,
           operand_a, operand_b, old_dest,
    output ready
  );
endinterface

interface aio_out_if import aio_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t result;

  modport source (output valid, result, input ready);
  modport sink (input valid, result, output ready);
endinterface

### rtl/alpha_integer_operate_alu_unit.sv
// Alpha integer operate unit. Each input word carries the operation controls,
// operands a and b and the old destination value, and yields one 64-bit result.
// The unit is a two-register pipeline: the input word is captured, all operations
// are evaluated in one pass of shallow logic, and the result is registered. A word
// is taken every cycle as long as the result side keeps up; an accepted word moves
// from the input register into the result register when that register is empty or
// being emptied, and leaves from there. Ready drops only when both the input
// register and the result register are full and the result is not being taken.
module alpha_integer_operate_alu_unit
  import aio_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  aio_in_if.sink    in_ch,
  aio_out_if.source out_ch
);

  // input stage
  logic              s1_valid_r, s1_valid_nxt;
  logic [FUNC_W-1:0] s1_func_r;
  logic              s1_inv_r;
  logic [1:0]        s1_scale_r;
  logic              s1_lw_r;
  logic [1:0]        s1_bw_r;
  logic              s1_hi_r;
  logic [COND_W-1:0] s1_cond_r;
  data_t             s1_a_r;
  data_t             s1_b_r;
  data_t             s1_old_r;

  // result stage
  logic  out_valid_r, out_valid_nxt;
  data_t result_r, result_nxt;

  logic in_accept;
  logic advance;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = result_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r  <= in_ch.func;
      s1_inv_r   <= in_ch.invert_b;
      s1_scale_r <= in_ch.scale;
      s1_lw_r    <= in_ch.longword;
      s1_bw_r    <= in_ch.byte_width;
      s1_hi_r    <= in_ch.high_part;
      s1_cond_r  <= in_ch.cond;
      s1_a_r     <= in_ch.operand_a;
      s1_b_r     <= in_ch.operand_b;
      s1_old_r   <= in_ch.old_dest;
    end
    if (advance && s1_valid_r) begin
      result_r <= result_nxt;
    end
  end

  // datapath
  data_t      b_log;
  data_t      a_scaled;
  data_t      sum;
  data_t      wmask;
  data_t      bmask;
  data_t      keep;
  data_t      a_field;
  data_t      msk;
  logic [5:0] sh;
  logic [5:0] pos;
  logic [5:0] neg_pos;
  logic       a_zero;
  logic       a_neg;
  logic       slt;
  logic       cmov_take;
  logic       is_cmp;
  logic [7:0] bge;

  always_comb begin
    b_log   = s1_inv_r ? ~s1_b_r : s1_b_r;
    sh      = s1_b_r[5:0];
    pos     = {s1_b_r[2:0], 3'b000};
    neg_pos = 6'(7'd64 - {1'b0, pos});
    a_zero  = (s1_a_r == '0);
    a_neg   = s1_a_r[DATA_W-1];
    slt     = $signed(s1_a_r) < $signed(s1_b_r);
    is_cmp  = s1_func_r inside {[FUNC_CMPEQ:FUNC_CMPULE]};

    case (s1_scale_r)
      SCALE_X4: a_scaled = {s1_a_r[DATA_W-3:0], 2'b00};
      SCALE_X8: a_scaled = {s1_a_r[DATA_W-4:0], 3'b000};
      default:  a_scaled = s1_a_r;
    endcase

    sum = (s1_func_r == FUNC_SUB) ? a_scaled - s1_b_r : a_scaled + s1_b_r;
    if (s1_lw_r) begin
      sum = {{32{sum[31]}}, sum[31:0]};
    end

    case (s1_bw_r)
      BW_BYTE: wmask = 64'h0000_0000_0000_00ff;
      BW_WORD: wmask = 64'h0000_0000_0000_ffff;
      BW_LONG: wmask = 64'h0000_0000_ffff_ffff;
      default: wmask = '1;
    endcase

    for (int i = 0; i < 8; i++) begin
      keep[8*i +: 8] = {8{!b_log[i]}};
      bge[i]         = s1_a_r[8*i +: 8] >= s1_b_r[8*i +: 8];
    end

    case (s1_cond_r)
      COND_EQ:  cmov_take = a_zero;
      COND_NE:  cmov_take = !a_zero;
      COND_LT:  cmov_take = a_neg;
      COND_GE:  cmov_take = !a_neg;
      COND_LE:  cmov_take = a_neg || a_zero;
      COND_GT:  cmov_take = !a_neg && !a_zero;
      COND_LBS: cmov_take = s1_a_r[0];
      COND_LBC: cmov_take = !s1_a_r[0];
      default:  cmov_take = 1'b0;
    endcase

    a_field = s1_a_r & wmask;
    // high variants at byte offset zero: mask covers nothing
    if (!s1_hi_r) begin
      bmask = wmask << pos;
    end else if (pos == '0) begin
      bmask = '0;
    end else begin
      bmask = wmask >> neg_pos;
    end
    msk = s1_a_r & ~bmask;

    case (s1_func_r)
      FUNC_ADD, FUNC_SUB: result_nxt = sum;
      FUNC_AND:    result_nxt = s1_a_r & b_log;
      FUNC_OR:     result_nxt = s1_a_r | b_log;
      FUNC_XOR:    result_nxt = s1_a_r ^ b_log;
      FUNC_SLL:    result_nxt = s1_a_r << sh;
      FUNC_SRL:    result_nxt = s1_a_r >> sh;
      FUNC_SRA:    result_nxt = data_t'($signed(s1_a_r) >>> sh);
      FUNC_ZAP:    result_nxt = s1_a_r & keep;
      FUNC_CMPEQ:  result_nxt = data_t'(s1_a_r == s1_b_r);
      FUNC_CMPLT:  result_nxt = data_t'(slt);
      FUNC_CMPLE:  result_nxt = data_t'(slt || (s1_a_r == s1_b_r));
      FUNC_CMPULT: result_nxt = data_t'(s1_a_r < s1_b_r);
      FUNC_CMPULE: result_nxt = data_t'(s1_a_r <= s1_b_r);
      FUNC_CMPBGE: result_nxt = data_t'(bge);
      FUNC_CMOV:   result_nxt = cmov_take ? s1_b_r : s1_old_r;
      FUNC_INS: begin
        if (!s1_hi_r) begin
          result_nxt = a_field << pos;
        end else if (pos == '0) begin
          result_nxt = '0;
        end else begin
          result_nxt = a_field >> neg_pos;
        end
      end
      // shift by neg_pos is zero at offset zero, giving a unshifted
      FUNC_EXT:    result_nxt = s1_hi_r ? ((s1_a_r << neg_pos) & wmask)
                                        : ((s1_a_r >> pos) & wmask);
      FUNC_MSK:    result_nxt = msk;
      default:     result_nxt = '0;
    endcase
  end

  // checks
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a captured input word");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled while pipeline can move");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && (s1_func_r > FUNC_MSK)) |=> (result_r == '0))
    else $error("unused operation gave nonzero result");

  a_cmp_bool: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && is_cmp) |=> (result_r[DATA_W-1:1] == '0))
    else $error("compare result not 0 or 1");

  a_cmpbge_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && (s1_func_r == FUNC_CMPBGE)) |=> (result_r[DATA_W-1:8] == '0))
    else $error("cmpbge result wider than eight bits");

endmodule

### verif/tb_alpha_integer_operate_alu_unit.sv
`timescale 1ns / 1ps

module tb_alpha_integer_operate_alu_unit;
  import aio_pkg::*;

  localparam logic [1:0]        SCALE_X1     = 2'd0;
  localparam logic [1:0]        SCALE_UNUSED = 2'd3;
  localparam logic [1:0]        BW_QUAD      = 2'd3;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 5'd31;
  localparam int                RAND_PER_PHASE = 640;
  localparam int                HOLD_CYCLES    = 60;

  localparam data_t ALL_ONES = {DATA_W{1'b1}};
  localparam data_t MIN_NEG  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam data_t MAX_POS  = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              invert_b;
    logic [1:0]        scale;
    logic              longword;
    logic [1:0]        byte_width;
    logic              high_part;
    logic [COND_W-1:0] cond;
    data_t             operand_a;
    data_t             operand_b;
    data_t             old_dest;
  } alu_op_t;

  class alu_scoreboard;
    data_t       expected_q[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
    endfunction

    function data_t predict_result(alu_op_t w);
      data_t       a;
      data_t       b;
      data_t       b_eff;
      data_t       a_sc;
      data_t       wm;
      data_t       m;
      data_t       r;
      logic [5:0]  sh;
      int unsigned pos;
      logic        a_neg;
      logic        take;
      a     = w.operand_a;
      b     = w.operand_b;
      b_eff = w.invert_b ? ~b : b;
      sh    = b[5:0];
      pos   = b[2:0] * 8;
      a_neg = a[DATA_W-1];
      r     = '0;
      case (w.byte_width)
        BW_BYTE: wm = 64'hff;
        BW_WORD: wm = 64'hffff;
        BW_LONG: wm = 64'hffff_ffff;
        default: wm = ALL_ONES;
      endcase
      case (w.scale)
        SCALE_X4: a_sc = a << 2;
        SCALE_X8: a_sc = a << 3;
        default:  a_sc = a;
      endcase
      case (w.func)
        FUNC_ADD, FUNC_SUB: begin
          r = (w.func == FUNC_ADD) ? a_sc + b : a_sc - b;
          if (w.longword) r = {{32{r[31]}}, r[31:0]};
        end
        FUNC_AND:    r = a & b_eff;
        FUNC_OR:     r = a | b_eff;
        FUNC_XOR:    r = a ^ b_eff;
        FUNC_SLL:    r = a << sh;
        FUNC_SRL:    r = a >> sh;
        FUNC_SRA:    r = data_t'($signed(a) >>> sh);
        FUNC_ZAP: begin
          for (int i = 0; i < 8; i++) r[8*i +: 8] = b_eff[i] ? 8'h00 : a[8*i +: 8];
        end
        FUNC_CMPEQ:  r = data_t'(a == b);
        FUNC_CMPLT:  r = data_t'($signed(a) < $signed(b));
        FUNC_CMPLE:  r = data_t'($signed(a) <= $signed(b));
        FUNC_CMPULT: r = data_t'(a < b);
        FUNC_CMPULE: r = data_t'(a <= b);
        FUNC_CMPBGE: begin
          // bit i reflects byte i
          for (int i = 0; i < 8; i++) r[i] = a[8*i +: 8] >= b[8*i +: 8];
        end
        FUNC_CMOV: begin
          case (w.cond)
            COND_EQ:  take = (a == '0);
            COND_NE:  take = (a != '0);
            COND_LT:  take = a_neg;
            COND_GE:  take = !a_neg;
            COND_LE:  take = a_neg || (a == '0);
            COND_GT:  take = !a_neg && (a != '0);
            COND_LBS: take = a[0];
            default:  take = !a[0];
          endcase
          r = take ? b : w.old_dest;
        end
        FUNC_INS: begin
          if (!w.high_part) r = (a & wm) << pos;
          else r = (pos == 0) ? '0 : ((a & wm) >> (64 - pos));
        end
        FUNC_EXT: begin
          if (!w.high_part) r = (a >> pos) & wm;
          else r = ((pos == 0) ? a : (a << (64 - pos))) & wm;
        end
        FUNC_MSK: begin
          if (!w.high_part) m = wm << pos;
          else m = (pos == 0) ? '0 : (wm >> (64 - pos));
          r = a & ~m;
        end
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_accepted(alu_op_t w);
      expected_q.push_back(predict_result(w));
    endfunction

    function void check_result(data_t got);
      data_t want;
      if (expected_q.size() == 0) begin
        $error("result: none expected, got %h", got);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $error("result: expected %h, got %h", want, got);
          fail_count++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  aio_in_if  in_ch();
  aio_out_if out_ch();

  alpha_integer_operate_alu_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alu_scoreboard ledger;
  int unsigned   snd_idle_pct;
  int unsigned   rcv_idle_pct;
  int unsigned   hold_requests;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      ledger.note_accepted('{in_ch.func, in_ch.invert_b, in_ch.scale, in_ch.longword,
                             in_ch.byte_width, in_ch.high_part, in_ch.cond,
                             in_ch.operand_a, in_ch.operand_b, in_ch.old_dest});
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) ledger.check_result(out_ch.result);
  end

  // result side: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  function automatic alu_op_t mk(logic [FUNC_W-1:0] func, logic inv, logic [1:0] scale,
                                 logic lw, logic [1:0] bw, logic hi, logic [COND_W-1:0] cond,
                                 data_t a, data_t b, data_t old);
    alu_op_t w;
    w = '{func, inv, scale, lw, bw, hi, cond, a, b, old};
    return w;
  endfunction

  function automatic data_t pick_value();
    data_t v;
    case ($urandom_range(11))
      0:       v = '0;
      1:       v = ALL_ONES;
      2:       v = MIN_NEG;
      3:       v = MAX_POS;
      4:       v = data_t'($urandom_range(255));
      5:       v = {32'h0, $urandom};
      6:       v = data_t'($urandom_range(1));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic alu_op_t random_op();
    alu_op_t w;
    // mostly defined operations, now and then an unused code
    w.func       = ($urandom_range(9) == 0) ? FUNC_W'($urandom_range(31))
                                            : FUNC_W'($urandom_range(18));
    w.invert_b   = 1'($urandom_range(1));
    w.scale      = 2'($urandom_range(3));
    w.longword   = 1'($urandom_range(1));
    w.byte_width = 2'($urandom_range(3));
    w.high_part  = 1'($urandom_range(1));
    w.cond       = COND_W'($urandom_range(7));
    w.operand_a  = pick_value();
    case ($urandom_range(7))
      0, 1:    w.operand_b = data_t'($urandom_range(255));
      2:       w.operand_b = w.operand_a;
      default: w.operand_b = pick_value();
    endcase
    w.old_dest   = {$urandom, $urandom};
    return w;
  endfunction

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic issue(input alu_op_t w);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.func       = w.func;
    in_ch.invert_b   = w.invert_b;
    in_ch.scale      = w.scale;
    in_ch.longword   = w.longword;
    in_ch.byte_width = w.byte_width;
    in_ch.high_part  = w.high_part;
    in_ch.cond       = w.cond;
    in_ch.operand_a  = w.operand_a;
    in_ch.operand_b  = w.operand_b;
    in_ch.old_dest   = w.old_dest;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic issue_random(input int n);
    repeat (n) issue(random_op());
  endtask

  initial begin
    ledger        = new();
    snd_idle_pct  = 21;
    rcv_idle_pct  = 59;
    hold_requests = 0;
    rst_n = 1'b0;
    issue_reset_values();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    issue(mk(FUNC_ADD, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, ALL_ONES, 64'd1, '0));
    issue(mk(FUNC_ADD, 1'b0, SCALE_X4, 1'b1, BW_BYTE, 1'b0, COND_EQ,
             64'h2000_0000, 64'd0, '0));
    issue(mk(FUNC_SUB, 1'b0, SCALE_X8, 1'b0, BW_BYTE, 1'b0, COND_EQ, MIN_NEG, 64'd1, '0));
    issue(mk(FUNC_SUB, 1'b0, SCALE_UNUSED, 1'b1, BW_BYTE, 1'b0, COND_EQ, 64'd5, 64'd7, '0));
    issue(mk(FUNC_AND, 1'b1, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, ALL_ONES, 64'hff, '0));
    issue(mk(FUNC_OR, 1'b1, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, '0, '0, '0));
    issue(mk(FUNC_XOR, 1'b1, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, ALL_ONES, ALL_ONES, '0));
    issue(mk(FUNC_SLL, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, 64'd1, 64'd63, '0));
    issue(mk(FUNC_SRL, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, MIN_NEG, ALL_ONES, '0));
    issue(mk(FUNC_SRA, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, MIN_NEG, 64'd0, '0));
    issue(mk(FUNC_SRA, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, MIN_NEG, 64'd63, '0));
    issue(mk(FUNC_ZAP, 1'b1, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, ALL_ONES, 64'h0f, '0));
    issue(mk(FUNC_CMPEQ, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, MAX_POS, MAX_POS, '0));
    issue(mk(FUNC_CMPLT, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, MIN_NEG, MAX_POS, '0));
    issue(mk(FUNC_CMPLE, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, MIN_NEG, MIN_NEG, '0));
    issue(mk(FUNC_CMPULT, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, '0, ALL_ONES, '0));
    issue(mk(FUNC_CMPULE, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ,
             ALL_ONES, ALL_ONES, '0));
    issue(mk(FUNC_CMPBGE, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ,
             64'h00ff_0180_7f00_ff01, 64'h0100_ff80_7f01_00ff, '0));
    issue(mk(FUNC_CMOV, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ,
             '0, 64'h1234, ALL_ONES));
    issue(mk(FUNC_CMOV, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_GT,
             MIN_NEG, 64'h1234, ALL_ONES));
    issue(mk(FUNC_INS, 1'b0, SCALE_X1, 1'b0, BW_QUAD, 1'b1, COND_EQ, ALL_ONES, 64'd0, '0));
    issue(mk(FUNC_INS, 1'b0, SCALE_X1, 1'b0, BW_BYTE, 1'b0, COND_EQ, ALL_ONES, 64'd7, '0));
    issue(mk(FUNC_EXT, 1'b0, SCALE_X1, 1'b0, BW_WORD, 1'b1, COND_EQ,
             64'h0123_4567_89ab_cdef, 64'd0, '0));
    issue(mk(FUNC_MSK, 1'b0, SCALE_X1, 1'b0, BW_LONG, 1'b1, COND_EQ, ALL_ONES, 64'd0, '0));
    issue(mk(FUNC_UNUSED, 1'b1, SCALE_X1, 1'b1, BW_QUAD, 1'b1, COND_LBC,
             ALL_ONES, ALL_ONES, ALL_ONES));

    issue_random(RAND_PER_PHASE);

    snd_idle_pct = 59;
    rcv_idle_pct = 21;
    issue_random(RAND_PER_PHASE);

    // no idling; stall the result side long enough to back up the input
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_requests++;
    issue_random(RAND_PER_PHASE);
    in_ch.valid = 1'b0;

    while (ledger.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (ledger.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  task automatic issue_reset_values();
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_ADD;
    in_ch.invert_b   = 1'b0;
    in_ch.scale      = SCALE_X1;
    in_ch.longword   = 1'b0;
    in_ch.byte_width = BW_BYTE;
    in_ch.high_part  = 1'b0;
    in_ch.cond       = COND_EQ;
    in_ch.operand_a  = '0;
    in_ch.operand_b  = '0;
    in_ch.old_dest   = '0;
  endtask

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
rtl/aio_pkg.sv
rtl/aio_if.sv
rtl/alpha_integer_operate_alu_unit.sv
verif/tb_alpha_integer_operate_alu_unit.sv
